@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also checks across reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/zsb_pkg.sv @@
// Shared types and constants for the zero-suppressing bitmap chunk block.
package zsb_pkg;

   localparam int CHUNK_MAX = 64;
   localparam int IDX_W     = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
   localparam int CNT_W     = $clog2(CHUNK_MAX + 1);
   localparam int SAMPLE_W  = 32;
   localparam int MAP_W     = 64;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_bits;
      logic                last_sample;
   } req_type;

   typedef struct packed {
      logic [MAP_W-1:0] out_word;
      logic             out_is_map;
      logic             out_last;
   } rsp_type;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      logic [SAMPLE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   typedef enum logic {
      PH_LOAD,
      PH_EMIT
   } phase_type;

   // Sign bit ignored: +0 and -0 are both zero.
   function automatic logic sample_nonzero(input logic [SAMPLE_W-1:0] s);
      sample_nonzero = |s[SAMPLE_W-2:0];
   endfunction

endpackage

@@ sv/zero_suppress_bitmap_chunk.sv @@
// Zero suppression of a chunk of float samples with a 64-bit presence map; top level.
// Samples are taken one per cycle and written to an on-chip store; a chunk closes on
// last_sample or when the store holds 64 samples. The closing transfer starts the emit
// phase, during which req_ready is low: the store is read back one entry per cycle
// while the output is not stalled (single read port, registered read data). Zeros
// after the first are still read back but produce no transfer. The first zero is
// replaced by the exact presence map, flagged by out_is_map; the oldest sample is the
// most significant used bit of the map. A chunk with no zero comes out unchanged. The
// final result word waits in the output register while the next chunk loads.
module zero_suppress_bitmap_chunk (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  zsb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output zsb_pkg::rsp_type rsp_data
);
   import zsb_pkg::*;

   ram_wr_type          ram_wr;
   ram_rd_type          ram_rd;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic                emit_valid;
   rsp_type             emit_data;
   logic                out_free;
   logic                out_valid_ff;
   rsp_type             out_data_ff;

   assign out_free = !out_valid_ff || rsp_ready;

   zsb_sample_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   zsb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data),
      .emit_valid  (emit_valid),
      .emit_data   (emit_data),
      .out_free    (out_free)
   );

   // Output register: load when free, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         out_data_ff <= emit_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ sv/zsb_sample_ram.sv @@
// Sample store: one write port, one read port, registered read data.
module zsb_sample_ram (
   input  logic                         clock,
   input  zsb_pkg::ram_wr_type          wr,
   input  zsb_pkg::ram_rd_type          rd,
   output logic [zsb_pkg::SAMPLE_W-1:0] rd_data
);
   import zsb_pkg::*;

   logic [SAMPLE_W-1:0] store_ff [CHUNK_MAX];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= store_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/zsb_ctrl.sv @@
// Chunk loader and emit sequencer: builds the presence map, then reads the store back.
module zsb_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  zsb_pkg::req_type             req_data,
   output zsb_pkg::ram_wr_type          ram_wr,
   output zsb_pkg::ram_rd_type          ram_rd,
   input  logic [zsb_pkg::SAMPLE_W-1:0] ram_rd_data,
   output logic                         emit_valid,
   output zsb_pkg::rsp_type             emit_data,
   input  logic                         out_free
);
   import zsb_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [MAP_W-1:0] map_ff, map_in;
   logic [IDX_W-1:0] fz_ff, fz_in;
   logic             fz_found_ff, fz_found_in;
   logic [IDX_W-1:0] lnz_ff, lnz_in;
   logic             nz_found_ff, nz_found_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic             accept;
   logic             in_nz;
   logic [IDX_W-1:0] slot;
   logic [CNT_W-1:0] fill_next;
   logic             closing;
   logic             issue;
   logic             pend_nz;
   logic             keep;
   logic             pend_take;
   logic [IDX_W-1:0] last_idx;

   assign slot      = fill_ff[IDX_W-1:0];
   assign in_nz     = sample_nonzero(req_data.sample_bits);
   assign fill_next = fill_ff + CNT_W'(1);
   assign closing   = req_data.last_sample || (fill_next == CNT_W'(CHUNK_MAX));

   // Index of the final word to emit: the later of the last nonzero and the first zero.
   always_comb begin
      if (!nz_found_ff) begin
         last_idx = fz_ff;
      end else if (!fz_found_ff) begin
         last_idx = lnz_ff;
      end else begin
         last_idx = (fz_ff > lnz_ff) ? fz_ff : lnz_ff;
      end
   end

   assign pend_nz   = sample_nonzero(ram_rd_data);
   assign keep      = pend_nz || (fz_found_ff && (pend_idx_ff == fz_ff));
   // Dropped zeros retire without needing the output slot.
   assign pend_take = pend_ff && (!keep || out_free);

   assign emit_valid          = pend_ff && keep;
   assign emit_data.out_word  = pend_nz ? {{(MAP_W-SAMPLE_W){1'b0}}, ram_rd_data} : map_ff;
   assign emit_data.out_is_map = !pend_nz;
   assign emit_data.out_last  = (pend_idx_ff == last_idx);

   always_comb begin
      phase_in    = phase_ff;
      fill_in     = fill_ff;
      map_in      = map_ff;
      fz_in       = fz_ff;
      fz_found_in = fz_found_ff;
      lnz_in      = lnz_ff;
      nz_found_in = nz_found_ff;
      rd_ptr_in   = rd_ptr_ff;
      pend_idx_in = pend_idx_ff;
      req_ready   = 1'b0;
      accept      = 1'b0;
      issue       = 1'b0;
      ram_wr.en   = 1'b0;
      ram_wr.addr = slot;
      ram_wr.data = req_data.sample_bits;
      ram_rd.en   = 1'b0;
      ram_rd.addr = rd_ptr_ff[IDX_W-1:0];

      case (phase_ff)
         PH_LOAD: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               ram_wr.en = 1'b1;
               fill_in   = fill_next;
               map_in    = {map_ff[MAP_W-2:0], in_nz};
               if (in_nz) begin
                  lnz_in      = slot;
                  nz_found_in = 1'b1;
               end else if (!fz_found_ff) begin
                  fz_in       = slot;
                  fz_found_in = 1'b1;
               end
               if (closing) begin
                  phase_in  = PH_EMIT;
                  rd_ptr_in = '0;
               end
            end
         end
         PH_EMIT: begin
            issue = (rd_ptr_ff < fill_ff) && (!pend_ff || pend_take);
            if (issue) begin
               ram_rd.en   = 1'b1;
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
               pend_idx_in = rd_ptr_ff[IDX_W-1:0];
            end
            // Last read retired: clear chunk state and reopen the input.
            if ((rd_ptr_ff == fill_ff) && pend_take) begin
               phase_in    = PH_LOAD;
               fill_in     = '0;
               map_in      = '0;
               fz_found_in = 1'b0;
               nz_found_in = 1'b0;
            end
         end
         default: begin
            phase_in = PH_LOAD;
         end
      endcase
   end

   always_comb begin
      if (issue) begin
         pend_in = 1'b1;
      end else if (pend_take) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LOAD;
         fill_ff     <= '0;
         map_ff      <= '0;
         fz_found_ff <= 1'b0;
         nz_found_ff <= 1'b0;
         rd_ptr_ff   <= '0;
         pend_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         map_ff      <= map_in;
         fz_found_ff <= fz_found_in;
         nz_found_ff <= nz_found_in;
         rd_ptr_ff   <= rd_ptr_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      fz_ff       <= fz_in;
      lnz_ff      <= lnz_in;
      pend_idx_ff <= pend_idx_in;
   end

endmodule

@@ sv/zsb_checker.sv @@
// Port-level checker for the zero-suppressing bitmap chunk block, with its bind.
`include "assert_macros.svh"

module zsb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input zsb_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input zsb_pkg::rsp_type rsp_data
);
   import zsb_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   `ASSERT_CLK(a_close_blocks_input, clock, reset, req_valid && req_ready && req_data.last_sample |=> !req_ready, "input open right after chunk close")

   `ASSERT_CLK(a_sample_word_shape, clock, reset, rsp_valid && !rsp_data.out_is_map |-> (rsp_data.out_word[MAP_W-1:SAMPLE_W] == '0) && (rsp_data.out_word[SAMPLE_W-2:0] != '0), "sample word is zero or not zero-extended")

   `ASSERT_CLK_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "bad state after reset")

endmodule

bind zero_suppress_bitmap_chunk zsb_checker u_zsb_checker (.*);
